[sv/firmware_section_validator_macros.svh]
// Assertion macros for the firmware section validator.
// Depends on nothing; the asserting module must provide clk and arst_n.
`ifndef FIRMWARE_SECTION_VALIDATOR_MACROS_SVH
`define FIRMWARE_SECTION_VALIDATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define FSV_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define FSV_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define FSV_ASSERT_IMP(lbl, cond, prop, msg)
`define FSV_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

[sv/fsv_pkg.sv]
// Types, constants and check functions for the firmware section validator.
// Depends on nothing; used by firmware_section_validator.
`default_nettype none

package fsv_pkg;

	localparam int unsigned WORD_W = 32;

	// item kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_SECTION = 1'b1;

	// configuration register indexes
	localparam logic REG_TARGET_BASE = 1'b0;
	localparam logic REG_TARGET_SPAN = 1'b1;

	localparam logic [WORD_W-1:0] FIRM_MAGIC  = 32'h4D52_4946;
	localparam logic [WORD_W-1:0] MIN_IMAGE   = 32'h0000_0200;
	localparam logic [WORD_W-1:0] SECTOR_MASK = 32'h0000_01FF;
	localparam logic [WORD_W-1:0] ADDR_MASK   = 32'h0000_000F;

	typedef enum logic [2:0] {
		N_OK           = 3'd0,
		N_BAD_HEADER   = 3'd1,
		N_NO_ENTRY     = 3'd2,
		N_MISALIGNED   = 3'd3,
		N_BEYOND_IMAGE = 3'd4,
		N_BAD_REGION   = 3'd5,
		N_HITS_TARGET  = 3'd6
	} nstat_t;

	typedef enum logic [2:0] {
		C_OK          = 3'd0,
		C_RENDERER    = 3'd1,
		C_FRAMEBUFFER = 3'd2,
		C_TOP_STUB    = 3'd3,
		C_HIGH_RAM    = 3'd4
	} cstat_t;

	localparam int unsigned NUM_WIN = 4;
	localparam logic [WORD_W-1:0] WIN_LO [NUM_WIN] = '{
		32'h0800_0000, 32'h1800_0000, 32'h1FF0_0000, 32'h2000_0000};
	localparam logic [WORD_W-1:0] WIN_HI [NUM_WIN] = '{
		32'h0810_0000, 32'h1860_0000, 32'h1FFF_FC00, 32'h2800_0000};

	// reserved regions, listed in priority order
	localparam int unsigned NUM_RES = 5;
	localparam logic [WORD_W-1:0] RES_LO [NUM_RES] = '{
		32'h1FFB_0000, 32'h1830_0000, 32'h1840_0000, 32'h2300_0000, 32'h1FFF_F000};
	localparam logic [WORD_W-1:0] RES_HI [NUM_RES] = '{
		32'h1FFB_E000, 32'h1837_E900, 32'h1847_E900, 32'h2310_0000, 32'h2000_0000};
	localparam cstat_t RES_CODE [NUM_RES] = '{
		C_RENDERER, C_FRAMEBUFFER, C_FRAMEBUFFER, C_HIGH_RAM, C_TOP_STUB};

	// Alignment, image fit, window fit and target overlap, first failure wins.
	function automatic nstat_t normal_check(
		input logic [WORD_W-1:0] off,
		input logic [WORD_W-1:0] sz,
		input logic [WORD_W-1:0] addr,
		input logic [WORD_W-1:0] img,
		input logic [WORD_W-1:0] base,
		input logic [WORD_W-1:0] span
	);
		logic [WORD_W:0] sec_end;
		logic [WORD_W:0] off_end;
		logic [WORD_W:0] tgt_end;
		logic            fits;
		nstat_t          code;
		sec_end = {1'b0, addr} + {1'b0, sz};
		off_end = {1'b0, off} + {1'b0, sz};
		tgt_end = {1'b0, base} + {1'b0, span};
		fits = 1'b0;
		for (int i = 0; i < NUM_WIN; i++) begin
			if (addr >= WIN_LO[i] && sec_end <= {1'b0, WIN_HI[i]})
				fits = 1'b1;
		end
		if ((off & SECTOR_MASK) != '0 || (sz & SECTOR_MASK) != '0 || (addr & ADDR_MASK) != '0)
			code = N_MISALIGNED;
		else if (off_end > {1'b0, img})
			code = N_BEYOND_IMAGE;
		else if (!fits)
			code = N_BAD_REGION;
		else if ({1'b0, addr} < tgt_end && sec_end > {1'b0, base})
			code = N_HITS_TARGET;
		else
			code = N_OK;
		return code;
	endfunction

	// Reserved region test; a wrapping section hits the first region.
	function automatic cstat_t concurrent_check(
		input logic [WORD_W-1:0] sz,
		input logic [WORD_W-1:0] addr
	);
		logic [WORD_W:0] sec_end;
		cstat_t          code;
		sec_end = {1'b0, addr} + {1'b0, sz};
		code = C_OK;
		for (int i = NUM_RES - 1; i >= 0; i--) begin
			if (sz != '0 && (sec_end[WORD_W] ||
			    (addr < RES_HI[i] && sec_end > {1'b0, RES_LO[i]})))
				code = RES_CODE[i];
		end
		return code;
	endfunction

endpackage

`default_nettype wire

[sv/firmware_section_validator.sv]
// Boot-image header and section validator, top level.
// Depends on fsv_pkg and firmware_section_validator_macros.svh.
//
// Usage:
//   Requests arrive on item_valid/item_ready. A request is either a header
//   (kind = header: magic_word, entry_point, image_size) or a section
//   (kind = section: sec_offset, sec_size, sec_address, last). A header
//   clears the concurrent code, sets the normal code from its own checks
//   and latches the image size; sections of nonzero size are checked and
//   each check keeps its first error. A section with last set gives one
//   result (normal_status, concurrent_status) on result_valid/result_ready;
//   others give nothing. The user must write target_base and target_span
//   (cfg_we/cfg_index/cfg_data) only while idle; the block does not check.
// Timing:
//   One request per cycle, unless a result is blocked. A request is held in
//   the input register, the checks run there and the error state and
//   result register update as it leaves, so result_valid is registered
//   behind the input register; a blocked result can hold it there.
//   The one-cycle rate is set by the error state loop, which closes within
//   that single stage.
// Stall and reset:
//   While a result waits on result_ready the input register still drains
//   non-result requests; only a second pending result stalls item_ready.
//   Reset clears the error codes, the image size, the target registers
//   and all valid flags.
`default_nettype none

module firmware_section_validator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        kind,
	input  wire logic [31:0] magic_word,
	input  wire logic [31:0] entry_point,
	input  wire logic [31:0] image_size,
	input  wire logic [31:0] sec_offset,
	input  wire logic [31:0] sec_size,
	input  wire logic [31:0] sec_address,
	input  wire logic        last,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       normal_status,
	output logic [2:0]       concurrent_status
);

	`include "firmware_section_validator_macros.svh"

	// configuration
	logic [31:0] target_base_q;
	logic [31:0] target_span_q;

	// input register
	logic        s1_valid_q;
	logic        kind_s1;
	logic [31:0] magic_s1;
	logic [31:0] entry_s1;
	logic [31:0] size_s1;
	logic [31:0] off_s1;
	logic [31:0] ssize_s1;
	logic [31:0] addr_s1;
	logic        last_s1;

	// running state
	fsv_pkg::nstat_t nerr_q, nerr_next;
	fsv_pkg::cstat_t cerr_q, cerr_next;
	logic [31:0]     img_size_q;

	logic out_free;
	logic s1_emits;
	logic s1_adv;
	logic item_take;

	// Write the target registers on request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_base_q <= '0;
			target_span_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fsv_pkg::REG_TARGET_BASE: target_base_q <= cfg_data;
				fsv_pkg::REG_TARGET_SPAN: target_span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input stage unless it holds a result with nowhere to go.
	assign out_free   = !result_valid || result_ready;
	assign s1_emits   = s1_valid_q && (kind_s1 == fsv_pkg::KIND_SECTION) && last_s1;
	assign s1_adv     = s1_valid_q && (!s1_emits || out_free);
	assign item_ready = !s1_valid_q || s1_adv;
	assign item_take  = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (item_take)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	// Capture the request payload.
	always_ff @(posedge clk) begin
		if (item_take) begin
			kind_s1  <= kind;
			magic_s1 <= magic_word;
			entry_s1 <= entry_point;
			size_s1  <= image_size;
			off_s1   <= sec_offset;
			ssize_s1 <= sec_size;
			addr_s1  <= sec_address;
			last_s1  <= last;
		end
	end

	// Next error codes: a header restarts both checks, a section keeps
	// the first failure of each.
	always_comb begin
		nerr_next = nerr_q;
		cerr_next = cerr_q;
		if (kind_s1 == fsv_pkg::KIND_HEADER) begin
			cerr_next = fsv_pkg::C_OK;
			if (size_s1 < fsv_pkg::MIN_IMAGE || magic_s1 != fsv_pkg::FIRM_MAGIC)
				nerr_next = fsv_pkg::N_BAD_HEADER;
			else if (entry_s1 == '0)
				nerr_next = fsv_pkg::N_NO_ENTRY;
			else
				nerr_next = fsv_pkg::N_OK;
		end else if (ssize_s1 != '0) begin
			if (nerr_q == fsv_pkg::N_OK)
				nerr_next = fsv_pkg::normal_check(off_s1, ssize_s1, addr_s1,
					img_size_q, target_base_q, target_span_q);
			if (cerr_q == fsv_pkg::C_OK)
				cerr_next = fsv_pkg::concurrent_check(ssize_s1, addr_s1);
		end
	end

	// Update the error state and image size as each request leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nerr_q     <= fsv_pkg::N_OK;
			cerr_q     <= fsv_pkg::C_OK;
			img_size_q <= '0;
		end else if (s1_adv) begin
			nerr_q <= nerr_next;
			cerr_q <= cerr_next;
			if (kind_s1 == fsv_pkg::KIND_HEADER)
				img_size_q <= size_s1;
		end
	end

	// Result register: load on a last section, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (s1_adv && s1_emits)
			result_valid <= 1'b1;
		else if (result_ready)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_emits) begin
			normal_status     <= nerr_next;
			concurrent_status <= cerr_next;
		end
	end

	`FSV_ASSERT_NEXT(a_emit_loads_result, s1_adv && s1_emits, result_valid,
		"last section did not load the result register")
	`FSV_ASSERT_IMP(a_stall_only_on_full, !item_ready,
		s1_valid_q && result_valid && !result_ready,
		"input stalled without a blocked result")
	`FSV_ASSERT_NEXT(a_normal_first_wins,
		s1_adv && kind_s1 == fsv_pkg::KIND_SECTION && nerr_q != fsv_pkg::N_OK,
		nerr_q == $past(nerr_q), "normal error overwritten by a section")
	`FSV_ASSERT_NEXT(a_header_restart, s1_adv && kind_s1 == fsv_pkg::KIND_HEADER,
		cerr_q == fsv_pkg::C_OK && img_size_q == $past(size_s1),
		"header did not restart the checks")

endmodule

`default_nettype wire

[sim/fsv_checker.sv]
// Checker for the firmware section validator: watches the request, result and register ports.
// Predicts both statuses from its own copy of the error state and the target area.
// Depends on fsv_pkg for the item kinds, register indexes and status codes.
module fsv_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic        kind,
	input  logic [31:0] magic_word,
	input  logic [31:0] entry_point,
	input  logic [31:0] image_size,
	input  logic [31:0] sec_offset,
	input  logic [31:0] sec_size,
	input  logic [31:0] sec_address,
	input  logic        last,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [2:0]  normal_status,
	input  logic [2:0]  concurrent_status,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	import fsv_pkg::*;

	typedef struct packed {
		nstat_t nst;
		cstat_t cst;
	} status_pair_t;

	status_pair_t status_q[$];

	nstat_t      norm_err;
	cstat_t      conc_err;
	logic [31:0] img_len;
	logic [31:0] tgt_base;
	logic [31:0] tgt_span;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count = fail_count + 1;
	endtask

	function automatic logic overlaps(input logic [31:0] addr, input logic [32:0] load_end,
			input logic [31:0] lo, input logic [31:0] hi);
		return addr < hi && load_end > {1'b0, lo};
	endfunction

	function automatic nstat_t judge_section(input logic [31:0] off, input logic [31:0] sz,
			input logic [31:0] addr);
		logic [32:0] load_end;
		logic [32:0] file_end;
		logic [32:0] tgt_end;
		logic        in_window;
		load_end = {1'b0, addr} + {1'b0, sz};
		file_end = {1'b0, off} + {1'b0, sz};
		tgt_end  = {1'b0, tgt_base} + {1'b0, tgt_span};
		in_window = (addr >= 32'h0800_0000 && load_end <= 33'h0_0810_0000) ||
			(addr >= 32'h1800_0000 && load_end <= 33'h0_1860_0000) ||
			(addr >= 32'h1FF0_0000 && load_end <= 33'h0_1FFF_FC00) ||
			(addr >= 32'h2000_0000 && load_end <= 33'h0_2800_0000);
		if ((off & 32'h1FF) != 0 || (sz & 32'h1FF) != 0 || (addr & 32'hF) != 0)
			return N_MISALIGNED;
		if (file_end > {1'b0, img_len})
			return N_BEYOND_IMAGE;
		if (!in_window)
			return N_BAD_REGION;
		if ({1'b0, addr} < tgt_end && load_end > {1'b0, tgt_base})
			return N_HITS_TARGET;
		return N_OK;
	endfunction

	function automatic cstat_t scan_reserved(input logic [31:0] sz, input logic [31:0] addr);
		logic [32:0] load_end;
		load_end = {1'b0, addr} + {1'b0, sz};
		// a load that wraps past 32 bits counts as the renderer hit
		if (sz == 0)
			return C_OK;
		if (load_end[32] || overlaps(addr, load_end, 32'h1FFB_0000, 32'h1FFB_E000))
			return C_RENDERER;
		if (overlaps(addr, load_end, 32'h1830_0000, 32'h1837_E900) ||
				overlaps(addr, load_end, 32'h1840_0000, 32'h1847_E900))
			return C_FRAMEBUFFER;
		if (overlaps(addr, load_end, 32'h2300_0000, 32'h2310_0000))
			return C_HIGH_RAM;
		if (overlaps(addr, load_end, 32'h1FFF_F000, 32'h2000_0000))
			return C_TOP_STUB;
		return C_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_pair_t want;
		if (!arst_n) begin
			norm_err = N_OK;
			conc_err = C_OK;
			img_len  = '0;
			tgt_base = '0;
			tgt_span = '0;
			status_q.delete();
			fail_count = 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (status_q.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d with nothing expected",
						normal_status, concurrent_status));
				end else begin
					want = status_q.pop_front();
					if (normal_status !== want.nst)
						report_mismatch($sformatf("result %0d normal_status %0d, expected %0d",
							results_seen, normal_status, want.nst));
					if (concurrent_status !== want.cst)
						report_mismatch($sformatf("result %0d concurrent_status %0d, expected %0d",
							results_seen, concurrent_status, want.cst));
				end
				results_seen <= results_seen + 1;
			end
			if (item_valid && item_ready) begin
				if (kind == KIND_HEADER) begin
					img_len  = image_size;
					conc_err = C_OK;
					if (image_size < MIN_IMAGE || magic_word != FIRM_MAGIC)
						norm_err = N_BAD_HEADER;
					else if (entry_point == 0)
						norm_err = N_NO_ENTRY;
					else
						norm_err = N_OK;
				end else begin
					if (sec_size != 0) begin
						if (norm_err == N_OK)
							norm_err = judge_section(sec_offset, sec_size, sec_address);
						if (conc_err == C_OK)
							conc_err = scan_reserved(sec_size, sec_address);
					end
					if (last)
						status_q.push_back('{norm_err, conc_err});
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_TARGET_BASE)
					tgt_base = cfg_data;
				else
					tgt_span = cfg_data;
			end
			pending <= status_q.size();
		end
	end

endmodule

[sim/tb_firmware_section_validator.sv]
// Testbench top for the firmware section validator: clock, reset, requests and verdict.
// Depends on fsv_pkg, firmware_section_validator and fsv_checker.
module tb_firmware_section_validator;
	import fsv_pkg::*;

	// quiet cycles allowed before the run is declared hung
	localparam int STALL_LIMIT = 500;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 125;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_TARGET_BASE;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        kind = KIND_HEADER;
	logic [31:0] magic_word = '0;
	logic [31:0] entry_point = '0;
	logic [31:0] image_size = '0;
	logic [31:0] sec_offset = '0;
	logic [31:0] sec_size = '0;
	logic [31:0] sec_address = '0;
	logic        last = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  normal_status;
	logic [2:0]  concurrent_status;

	int fail_count;
	int pending;
	int results_seen;

	// percentage of idle bursts on both sides; zero means a clean stretch
	int          idle_pct = 0;
	int          items_sent = 0;
	int          rr_hold = 0;
	int          quiet_cycles = 0;
	// stimulus copy of the target area, used only to aim sections at its edges
	logic [31:0] cur_base = '0;
	logic [31:0] cur_span = '0;

	firmware_section_validator u_top (.*);

	fsv_checker u_check (.*);

	always #2 clk = ~clk;

	// Receiver: hold result_ready in random bursts.
	always @(posedge clk) begin
		if (rr_hold != 0) begin
			rr_hold <= rr_hold - 1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			result_ready <= 1'b0;
			rr_hold <= $urandom_range(0, 6);
		end else begin
			result_ready <= 1'b1;
			rr_hold <= $urandom_range(0, 6);
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("firmware_section_validator regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request, optionally after an idle burst, and wait for acceptance.
	// Valid stays high into the next request when there is no burst.
	task automatic push_request(input logic k, input logic [31:0] mw, input logic [31:0] ep,
			input logic [31:0] isz, input logic [31:0] off, input logic [31:0] sz,
			input logic [31:0] addr, input logic lst);
		int unsigned gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 7) : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		kind        <= k;
		magic_word  <= mw;
		entry_point <= ep;
		image_size  <= isz;
		sec_offset  <= off;
		sec_size    <= sz;
		sec_address <= addr;
		last        <= lst;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// Header request; fill the section fields with noise since the block ignores them.
	task automatic send_header(input logic [31:0] mw, input logic [31:0] ep,
			input logic [31:0] isz);
		push_request(KIND_HEADER, mw, ep, isz, $urandom, $urandom, $urandom,
			$urandom_range(0, 1));
	endtask

	// Section request; fill the header fields with noise.
	task automatic send_section(input logic [31:0] off, input logic [31:0] sz,
			input logic [31:0] addr, input logic lst);
		push_request(KIND_SECTION, $urandom, $urandom, $urandom, off, sz, addr, lst);
	endtask

	// Drop valid, wait for every expected result, then let the pipe drain.
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic write_target(input logic [31:0] b, input logic [31:0] s);
		write_reg(REG_TARGET_BASE, b);
		write_reg(REG_TARGET_SPAN, s);
		cfg_we <= 1'b0;
		cur_base = b;
		cur_span = s;
	endtask

	// Build one section: mostly well formed inside the image and a window,
	// aimed at windows, reserved regions or target edges; the rest broken.
	task automatic make_section(input logic [31:0] ilen, output logic [31:0] off,
			output logic [31:0] sz, output logic [31:0] addr);
		int unsigned blocks;
		int unsigned room;
		int unsigned w;
		logic [31:0] anchor;
		blocks = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 16);
		sz     = blocks << 9;
		room   = ilen >> 9;
		off    = (room >= blocks) ? ($urandom_range(0, room - blocks) << 9) : 32'h0;
		case ($urandom_range(0, 2))
			0: begin
				w = $urandom_range(0, NUM_WIN - 1);
				addr = WIN_LO[w] + ($urandom_range(0, (WIN_HI[w] - WIN_LO[w] - sz) >> 4) << 4);
			end
			1: begin
				w = $urandom_range(0, NUM_RES - 1);
				anchor = $urandom_range(0, 1) ? RES_LO[w] : RES_HI[w];
				addr = (anchor - $urandom_range(0, sz)) & ~ADDR_MASK;
			end
			default: begin
				anchor = $urandom_range(0, 1) ? cur_base : cur_base + cur_span;
				addr = (anchor - $urandom_range(0, sz)) & ~ADDR_MASK;
			end
		endcase
		case ($urandom_range(0, 15))
			0: sz = 0;
			1: begin
				off  = $urandom;
				sz   = $urandom;
				addr = $urandom;
			end
			2: begin
				case ($urandom_range(0, 2))
					0: off = off | $urandom_range(1, SECTOR_MASK);
					1: sz = sz | $urandom_range(1, SECTOR_MASK);
					default: addr = addr | $urandom_range(1, ADDR_MASK);
				endcase
			end
			3: off = $urandom & ~SECTOR_MASK;
			4: addr = $urandom & ~ADDR_MASK;
			5: sz = $urandom & ~SECTOR_MASK;
			default: ;
		endcase
	endtask

	// One image: a header, mostly valid, then a few sections; now and then
	// the last mark is dropped so the next header lands mid-image.
	task automatic send_image();
		logic [31:0] ilen;
		logic [31:0] mw;
		logic [31:0] ep;
		logic [31:0] off;
		logic [31:0] sz;
		logic [31:0] addr;
		int unsigned nsec;
		logic        close;
		case ($urandom_range(0, 19))
			0: ilen = $urandom_range(0, MIN_IMAGE - 1);
			1: ilen = $urandom;
			2: ilen = 32'hFFFF_FFFF;
			default: ilen = $urandom_range(1, 4096) << 9;
		endcase
		mw = FIRM_MAGIC;
		if ($urandom_range(0, 15) == 0)
			mw = mw ^ (32'h1 << $urandom_range(0, 31));
		ep = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
		send_header(mw, ep, ilen);
		nsec  = $urandom_range(1, 6);
		close = ($urandom_range(0, 11) != 0);
		for (int unsigned i = 0; i < nsec; i++) begin
			make_section(ilen, off, sz, addr);
			send_section(off, sz, addr, close && i == nsec - 1);
		end
	endtask

	initial begin
		int unsigned stop;
		int unsigned w;
		logic [31:0] b;
		logic [31:0] s;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero-span target just inside the first window.
		write_target(32'h0800_1000, 32'h0);
		idle_pct = 20;
		// section ahead of any header sees an empty image
		send_section(32'h0, 32'h200, 32'h0800_0000, 1'b1);
		// zero entry point; concurrent check still runs
		send_header(FIRM_MAGIC, 32'h0, 32'h1000);
		send_section(32'h0, 32'h200, 32'h1FFB_0000, 1'b1);
		// wrong magic, framebuffer hit
		send_header(FIRM_MAGIC ^ 32'h1, 32'h1, 32'h1000);
		send_section(32'h200, 32'h200, 32'h1830_0000, 1'b1);
		// image too short; a wrapping load hits the renderer region
		send_header(FIRM_MAGIC, 32'hFFFF_FFFF, MIN_IMAGE - 1);
		send_section(32'h0, 32'h400, 32'hFFFF_FE00, 1'b1);
		// misaligned offset, then high RAM
		send_header(FIRM_MAGIC, 32'h1, 32'hFFFF_FFFF);
		send_section(32'h1, 32'h200, 32'h0800_0000, 1'b0);
		send_section(32'h0, 32'h200, 32'h2300_0000, 1'b1);
		// misaligned size, then top stub
		send_header(FIRM_MAGIC, 32'h1, 32'h1_0000);
		send_section(32'h0, 32'h201, 32'h0800_0000, 1'b0);
		send_section(32'h0, 32'h200, 32'h1FFF_F000, 1'b1);
		// misaligned address
		send_header(FIRM_MAGIC, 32'h1, 32'h1_0000);
		send_section(32'h0, 32'h200, 32'h0800_0008, 1'b1);
		// offset plus size wraps past 32 bits
		send_header(FIRM_MAGIC, 32'h1, 32'hFFFF_FFFF);
		send_section(32'hFFFF_FE00, 32'h400, 32'h0800_0000, 1'b1);
		// load ends exactly at 2^32: outside every window, renderer by wrap
		send_header(FIRM_MAGIC, 32'h1, 32'h1_0000);
		send_section(32'h0, 32'h400, 32'hFFFF_FC00, 1'b1);
		// straddles the zero-span target
		send_header(FIRM_MAGIC, 32'h1, 32'h1_0000);
		send_section(32'h0, 32'h2000, 32'h0800_0000, 1'b1);
		// clean image with a skipped zero-size section
		send_header(FIRM_MAGIC, 32'h1, 32'h1_0000);
		send_section(32'h0, 32'h200, 32'h0800_0000, 1'b0);
		send_section(32'h200, 32'h0, 32'h0, 1'b0);
		send_section(32'h200, 32'h200, 32'h2000_0000, 1'b1);

		// Random phases, each under its own target area and idle density.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					b = 32'h0;
					s = 32'h0;
					idle_pct = 30;
				end
				1: begin
					b = 32'hFFFF_FFFF;
					s = 32'hFFFF_FFFF;
					idle_pct = 50;
				end
				2: begin
					b = 32'h0;
					s = 32'hFFFF_FFFF;
					idle_pct = 0;
				end
				NUM_PHASES - 1: begin
					b = $urandom;
					s = $urandom;
					idle_pct = 0;
				end
				default: begin
					w = $urandom_range(0, NUM_WIN - 1);
					b = WIN_LO[w] + ($urandom_range(0, (WIN_HI[w] - WIN_LO[w]) >> 4) << 4);
					s = $urandom_range(0, 32'h4_0000);
					idle_pct = (p % 2 != 0) ? 60 : 20;
				end
			endcase
			// hold requests until every result is back before touching the registers
			settle();
			write_target(b, s);
			stop = items_sent + PHASE_ITEMS;
			while (items_sent < stop) begin
				if ($urandom_range(0, 6) == 0)
					push_request($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom_range(0, 1));
				else
					send_image();
			end
		end

		settle();
		repeat (4) @(posedge clk);
		$display("covered %0d requests under %0d target settings, %0d results checked",
			items_sent, NUM_PHASES + 1, results_seen);
		if (fail_count == 0 && pending == 0)
			$display("firmware_section_validator regression: pass");
		else
			$display("firmware_section_validator regression: fail");
		$finish;
	end

endmodule

[firmware_section_validator.f]
+incdir+sv
sv/fsv_pkg.sv
sv/firmware_section_validator.sv
sim/fsv_checker.sv
sim/tb_firmware_section_validator.sv
